[sv/cwvs_pkg.sv]
// ----------------------------------------------------------------------------
// cwvs_pkg
// Shared widths, constants, register indexes and payload types of the clip
// window voice scheduler.
// ----------------------------------------------------------------------------
package cwvs_pkg;

  localparam int TIME_W   = 63;
  localparam int TAG_W    = 32;
  localparam int IDX_W    = 16;
  localparam int COUNT_W  = 11;
  localparam int GAIN_W   = 16;
  localparam int GOUT_W   = 15;
  localparam int PROD_W   = 2 * GOUT_W;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = TIME_W;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_START  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_FRAMES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_VOICES    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ANY_SOLO      = 2'd3;

  localparam logic [COUNT_W-1:0] MAX_VOICES_RST = 11'd64;

  localparam longint unsigned MAX_CLIPS = 64'd65536;

  localparam logic signed [GAIN_W-1:0] UNITY_GAIN = 16'sd4096;
  localparam logic signed [GAIN_W-1:0] GAIN_MAX   = 16'sd16384;
  localparam logic signed [GAIN_W-1:0] PAN_ONE    = 16'sd16384;
  localparam logic [GOUT_W-1:0]        PAN_ONE_U  = 15'd16384;
  localparam logic [PROD_W-1:0]        ROUND_HALF = 30'd8192;
  localparam int                       PAN_SHIFT  = 14;

  localparam int QUEUE_DEPTH_DEF = 4;

  typedef struct packed {
    logic                     first_of_plan;
    logic [TIME_W-1:0]        clip_start;
    logic [TIME_W-1:0]        clip_end;
    logic [TAG_W-1:0]         clip_tag;
    logic [TAG_W-1:0]         track_tag;
    logic                     has_mix_state;
    logic                     track_muted;
    logic                     track_solo;
    logic signed [GAIN_W-1:0] track_gain;
    logic signed [GAIN_W-1:0] track_pan;
  } clip_t;

  typedef struct packed {
    logic               voice_emitted;
    logic               limit_reached;
    logic [IDX_W-1:0]   clip_index;
    logic [TAG_W-1:0]   voice_clip_tag;
    logic [TAG_W-1:0]   voice_track_tag;
    logic [TIME_W-1:0]  render_offset;
    logic [TIME_W-1:0]  timeline_start;
    logic [TIME_W-1:0]  clip_offset;
    logic [TIME_W-1:0]  voice_frames;
    logic [GOUT_W-1:0]  gain_left;
    logic [GOUT_W-1:0]  gain_right;
  } voice_t;

  // classified clip, front to back
  typedef struct packed {
    logic                     emit;
    logic                     limit;
    logic [IDX_W-1:0]         idx;
    logic [TAG_W-1:0]         clip_tag;
    logic [TAG_W-1:0]         track_tag;
    logic [TIME_W-1:0]        clip_start;
    logic [TIME_W-1:0]        clip_end;
    logic                     start_in_win;  // clip_start > window_start
    logic                     end_in_win;    // clip_end < window_end
    logic                     has_mix_state;
    logic signed [GAIN_W-1:0] gain;
    logic signed [GAIN_W-1:0] pan;
  } job_t;

  typedef struct packed {
    logic [TIME_W-1:0] start;
    logic [TIME_W-1:0] stop;
  } window_t;

endpackage

[sv/cwvs_stream_if.sv]
// ----------------------------------------------------------------------------
// cwvs_stream_if
// Valid/ready stream channel carrying one payload per transfer.
// ----------------------------------------------------------------------------
interface cwvs_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[sv/clip_window_voice_scheduler_core.sv]
// ----------------------------------------------------------------------------
// clip_window_voice_scheduler_core
// Schedules clips against a render window and emits one voice result per
// clip, with offsets, length and pan gains.
// ----------------------------------------------------------------------------
//  channel     dir  payload   handshake
//  clip_in     in   clip_t    valid/ready
//  voice_out   out  voice_t   valid/ready
//  cfg_*       in   index+data, write on cfg_we, no back-pressure
//
//  One clip per cycle sustained while voice_out is not stalled. The front
//  classifies a clip into the job queue at its transfer edge, and the back
//  loads the output register from the queue head when that register is empty or being taken.
//  Plan counters live in the front and update on each transfer.
//  Synchronous reset clears the queue, output valid, counters and registers.
//  clip_in.ready drops only when the job queue is full, i.e. with voice_out
//  stalled, QUEUE_DEPTH jobs queued behind the result held at the output.
// ----------------------------------------------------------------------------
module clip_window_voice_scheduler_core #(
  parameter int QUEUE_DEPTH = cwvs_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [cwvs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cwvs_pkg::CFG_DATA_W-1:0]  cfg_data,
  cwvs_stream_if.sink                      clip_in,
  cwvs_stream_if.source                    voice_out
);
  import cwvs_pkg::*;

  logic    push;
  logic    full;
  logic    pop;
  logic    head_valid;
  job_t    push_job;
  job_t    head_job;
  window_t window;

  cwvs_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .clip_in    (clip_in),
    .queue_full (full),
    .push       (push),
    .job        (push_job),
    .window     (window)
  );

  cwvs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  cwvs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (head_valid),
    .job       (head_job),
    .window    (window),
    .pop       (pop),
    .voice_out (voice_out)
  );

endmodule

[sv/cwvs_front.sv]
// ----------------------------------------------------------------------------
// cwvs_front
// Configuration registers, plan counters and clip classification; pushes one
// classified job per accepted clip.
// ----------------------------------------------------------------------------
module cwvs_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [cwvs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cwvs_pkg::CFG_DATA_W-1:0]     cfg_data,
  cwvs_stream_if.sink                         clip_in,
  input  logic                                queue_full,
  output logic                                push,
  output cwvs_pkg::job_t                      job,
  output cwvs_pkg::window_t                   window
);
  import cwvs_pkg::*;

  logic [TIME_W-1:0]  window_start;
  logic [TIME_W-1:0]  window_frames;
  logic [TIME_W-1:0]  window_end;
  logic [COUNT_W-1:0] max_voices;
  logic               any_solo;

  logic [COUNT_W-1:0] voice_count;
  logic               stopped;
  logic [IDX_W-1:0]   clip_counter;

  logic [TIME_W:0]    end_sum;
  logic [TIME_W-1:0]  end_sat;
  logic               eff_stopped;
  logic [COUNT_W-1:0] eff_count;
  logic [IDX_W-1:0]   idx;
  logic [IDX_W:0]     idx_inc;
  logic [IDX_W-1:0]   clip_counter_next;
  logic               overlap;
  logic               audible;
  logic               candidate;
  logic               hit_limit;
  logic               emit;
  clip_t              c;

  assign c = clip_in.data;

  // window end saturates at the top of the 63-bit range; updated with the write
  always_comb begin
    end_sum = '0;
    unique case (cfg_index)
      REG_WINDOW_START:  end_sum = {1'b0, cfg_data} + {1'b0, window_frames};
      REG_WINDOW_FRAMES: end_sum = {1'b0, window_start} + {1'b0, cfg_data};
      default:           end_sum = {1'b0, window_start} + {1'b0, window_frames};
    endcase
    end_sat = end_sum[TIME_W] ? '1 : end_sum[TIME_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_start  <= '0;
      window_frames <= '0;
      window_end    <= '0;
      max_voices    <= MAX_VOICES_RST;
      any_solo      <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WINDOW_START: begin
          window_start <= cfg_data;
          window_end   <= end_sat;
        end
        REG_WINDOW_FRAMES: begin
          window_frames <= cfg_data;
          window_end    <= end_sat;
        end
        REG_MAX_VOICES: max_voices <= cfg_data[COUNT_W-1:0];
        REG_ANY_SOLO:   any_solo   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    eff_stopped = c.first_of_plan ? 1'b0 : stopped;
    eff_count   = c.first_of_plan ? '0 : voice_count;
    idx         = c.first_of_plan ? '0 : clip_counter;
    idx_inc     = {1'b0, idx} + 1'b1;
    clip_counter_next = (64'(idx_inc) >= MAX_CLIPS) ? '0 : idx_inc[IDX_W-1:0];

    overlap = (c.clip_end > window_start) && (c.clip_start < window_end);
    if (c.has_mix_state) begin
      audible = !c.track_muted && (!any_solo || c.track_solo);
    end else begin
      audible = !any_solo;
    end
    candidate = !eff_stopped && (window_frames != '0) && overlap && audible;
    hit_limit = candidate && (eff_count >= max_voices);
    emit      = candidate && !hit_limit && (c.clip_end > c.clip_start);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      voice_count  <= '0;
      stopped      <= 1'b0;
      clip_counter <= '0;
    end else if (push) begin
      voice_count  <= eff_count + COUNT_W'(emit);
      stopped      <= eff_stopped || hit_limit;
      clip_counter <= clip_counter_next;
    end
  end

  assign clip_in.ready = !queue_full;
  assign push          = clip_in.valid && !queue_full;

  always_comb begin
    job.emit          = emit;
    job.limit         = eff_stopped || hit_limit;
    job.idx           = idx;
    job.clip_tag      = c.clip_tag;
    job.track_tag     = c.track_tag;
    job.clip_start    = c.clip_start;
    job.clip_end      = c.clip_end;
    job.start_in_win  = c.clip_start > window_start;
    job.end_in_win    = c.clip_end < window_end;
    job.has_mix_state = c.has_mix_state;
    job.gain          = c.track_gain;
    job.pan           = c.track_pan;
  end

  assign window.start = window_start;
  assign window.stop  = window_end;

endmodule

[sv/cwvs_queue.sv]
// ----------------------------------------------------------------------------
// cwvs_queue
// Small FIFO of classified jobs between front and back.
// ----------------------------------------------------------------------------
module cwvs_queue #(
  parameter int DEPTH = cwvs_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  cwvs_pkg::job_t  push_job,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output cwvs_pkg::job_t  head_job
);
  import cwvs_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  job_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_pop;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head_job   = slots[rd_ptr];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[sv/cwvs_back.sv]
// ----------------------------------------------------------------------------
// cwvs_back
// Turns a classified job into a voice result: window clipping, offsets and
// pan gains, held in the output register.
// ----------------------------------------------------------------------------
module cwvs_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               job_valid,
  input  cwvs_pkg::job_t     job,
  input  cwvs_pkg::window_t  window,
  output logic               pop,
  cwvs_stream_if.source      voice_out
);
  import cwvs_pkg::*;

  logic                     out_valid;
  voice_t                   out_data;
  voice_t                   result;
  logic [TIME_W-1:0]        vs;
  logic [TIME_W-1:0]        ve;
  logic signed [GAIN_W-1:0] gain_in;
  logic signed [GAIN_W-1:0] pan_in;
  logic [GOUT_W-1:0]        g;
  logic [GOUT_W-1:0]        pan_mag;
  logic [GOUT_W-1:0]        factor;
  logic [PROD_W-1:0]        prod;
  logic [GOUT_W-1:0]        scaled;

  assign pop = job_valid && (!out_valid || voice_out.ready);

  always_comb begin
    vs = job.start_in_win ? job.clip_start : window.start;
    ve = job.end_in_win ? job.clip_end : window.stop;

    gain_in = job.has_mix_state ? job.gain : UNITY_GAIN;
    pan_in  = job.has_mix_state ? job.pan : '0;

    priority if (gain_in <= 0) begin
      g = '0;
    end else if (gain_in > GAIN_MAX) begin
      g = PAN_ONE_U;
    end else begin
      g = gain_in[GOUT_W-1:0];
    end

    // magnitude of the clamped pan; only the far side gets scaled
    priority if (pan_in > PAN_ONE || pan_in < -PAN_ONE) begin
      pan_mag = PAN_ONE_U;
    end else if (pan_in < 0) begin
      pan_mag = GOUT_W'(-pan_in);
    end else begin
      pan_mag = pan_in[GOUT_W-1:0];
    end
    factor = PAN_ONE_U - pan_mag;
    prod   = PROD_W'(g) * PROD_W'(factor) + ROUND_HALF;
    scaled = prod[PAN_SHIFT +: GOUT_W];

    result = '0;
    result.limit_reached = job.limit;
    result.clip_index    = job.idx;
    if (job.emit) begin
      result.voice_emitted   = 1'b1;
      result.voice_clip_tag  = job.clip_tag;
      result.voice_track_tag = job.track_tag;
      result.render_offset   = vs - window.start;
      result.timeline_start  = vs;
      result.clip_offset     = vs - job.clip_start;
      result.voice_frames    = ve - vs;
      result.gain_left       = (pan_in > 0) ? scaled : g;
      result.gain_right      = (pan_in < 0) ? scaled : g;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (voice_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data <= result;
    end
  end

  assign voice_out.valid = out_valid;
  assign voice_out.data  = out_data;

endmodule

[sv/cwvs_check.sv]
// ----------------------------------------------------------------------------
// cwvs_check
// Port-level checks on the voice result channel, bound to the top level.
// ----------------------------------------------------------------------------
module cwvs_check (
  input logic             clk,
  input logic             rst,
  input logic             voice_valid,
  input logic             voice_ready,
  input cwvs_pkg::voice_t voice_data
);
  import cwvs_pkg::*;

  a_reset_clears_valid: assert property (@(posedge clk) rst |=> !voice_valid)
    else $error("voice_out valid after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    voice_valid && !voice_ready |=> voice_valid && $stable(voice_data))
    else $error("stalled voice result changed");

  a_emit_excludes_limit: assert property (@(posedge clk) disable iff (rst)
    voice_valid |-> !(voice_data.voice_emitted && voice_data.limit_reached))
    else $error("voice emitted while limit flagged");

  a_no_voice_is_zero: assert property (@(posedge clk) disable iff (rst)
    voice_valid && !voice_data.voice_emitted |->
      voice_data.voice_frames == '0 && voice_data.gain_left == '0 &&
      voice_data.gain_right == '0 && voice_data.voice_clip_tag == '0)
    else $error("non-voice result carries payload");

  a_voice_sane: assert property (@(posedge clk) disable iff (rst)
    voice_valid && voice_data.voice_emitted |->
      voice_data.voice_frames != '0 && voice_data.gain_left <= PAN_ONE_U &&
      voice_data.gain_right <= PAN_ONE_U)
    else $error("voice has zero length or gain above 4.0");

endmodule

bind clip_window_voice_scheduler_core cwvs_check u_cwvs_check (
  .clk         (clk),
  .rst         (rst),
  .voice_valid (voice_out.valid),
  .voice_ready (voice_out.ready),
  .voice_data  (voice_out.data)
);
